@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Checks a next-cycle implication on every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/veas_pkg.sv @@
// Package with constants, types and tables of the edge alignment selector.
`timescale 1ns / 1ps
package veas_pkg;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN = 24;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    localparam logic [1:0] KIND_WEAK = 2'd0;
    localparam logic [1:0] KIND_FRONT = 2'd1;
    localparam logic [1:0] KIND_REAR = 2'd2;

    localparam logic REG_RATIO = 1'b0;
    localparam logic REG_ABS = 1'b1;

    function automatic logic signed [33:0] atan_turn32(input int i);
        logic signed [33:0] r;
        r = '0;
        case (i)
            0: r = 34'sd536870912;
            1: r = 34'sd316933406;
            2: r = 34'sd167458907;
            3: r = 34'sd85004756;
            4: r = 34'sd42667331;
            5: r = 34'sd21354465;
            6: r = 34'sd10679838;
            7: r = 34'sd5340245;
            8: r = 34'sd2670163;
            9: r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

@@ hw/rtl/vehicle_edge_alignment_select_top.sv @@
// Top level of the vehicle edge alignment selector.
//   channel  | direction | handshake
//   s_*      | in        | s_valid / s_ready
//   m_*      | out       | m_valid / m_ready
//   cfg_*    | in        | cfg_we, no wait
// One request enters per cycle while the pipeline advances; CORDIC_STEPS is capped at 24.
// The sine and cosine chains and the seven select stages form the pipeline.
// The whole pipeline advances when the output register is empty or taken.
// A stall freezes every stage; reset clears valid bits and loads the threshold registers with their defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vehicle_edge_alignment_select_top #(
    parameter int ANGLE_BITS = veas_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = veas_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_meas_x,
    input  logic signed [23:0] s_meas_y,
    input  logic [15:0]        s_meas_heading,
    input  logic [13:0]        s_meas_length,
    input  logic signed [23:0] s_pred_x,
    input  logic signed [23:0] s_pred_y,
    input  logic [15:0]        s_pred_heading,
    input  logic [13:0]        s_pred_length,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_update_kind,
    output logic signed [23:0] m_anchor_x,
    output logic signed [23:0] m_anchor_y,
    output logic [23:0]        m_edge_gap
);
    localparam int STEPS = (CORDIC_STEPS > veas_pkg::TABLE_LEN) ?
        veas_pkg::TABLE_LEN : CORDIC_STEPS;
    localparam int DLY = STEPS + 1;

    logic [15:0] ratio_reg, abs_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= 16'd13107;
            abs_reg <= 16'd256;
        end else if (cfg_we) begin
            unique case (cfg_index)
                veas_pkg::REG_RATIO: ratio_reg <= cfg_wdata;
                veas_pkg::REG_ABS: abs_reg <= cfg_wdata;
            endcase
        end
    end

    logic en;
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    logic signed [33:0] mc, ms, pc, ps;
    veas_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cm (
        .aclk(aclk), .en(en), .angle(ANGLE_BITS'(s_meas_heading)),
        .cos_q30(mc), .sin_q30(ms));
    veas_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cp (
        .aclk(aclk), .en(en), .angle(ANGLE_BITS'(s_pred_heading)),
        .cos_q30(pc), .sin_q30(ps));

    logic               v_reg [DLY];
    logic signed [23:0] mx_reg [DLY], my_reg [DLY], px_reg [DLY], py_reg [DLY];
    logic [13:0]        ml_reg [DLY], pl_reg [DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg[0] <= s_meas_x; my_reg[0] <= s_meas_y; ml_reg[0] <= s_meas_length;
            px_reg[0] <= s_pred_x; py_reg[0] <= s_pred_y; pl_reg[0] <= s_pred_length;
            for (int i = 1; i < DLY; i++) begin
                mx_reg[i] <= mx_reg[i-1]; my_reg[i] <= my_reg[i-1];
                ml_reg[i] <= ml_reg[i-1]; px_reg[i] <= px_reg[i-1];
                py_reg[i] <= py_reg[i-1]; pl_reg[i] <= pl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DLY; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= s_valid;
            for (int i = 1; i < DLY; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    veas_select u_sel (
        .aclk(aclk), .aresetn(aresetn), .en(en), .v_in(v_reg[DLY-1]),
        .mc(mc), .ms(ms), .pc(pc), .ps(ps),
        .mx(mx_reg[DLY-1]), .my(my_reg[DLY-1]), .ml(ml_reg[DLY-1]),
        .px(px_reg[DLY-1]), .py(py_reg[DLY-1]), .pl(pl_reg[DLY-1]),
        .ratio_thr(ratio_reg), .abs_thr(abs_reg),
        .v_out(m_valid), .kind(m_update_kind), .ax(m_anchor_x), .ay(m_anchor_y),
        .gap(m_edge_gap));

    `ASSERT_IMPL(a_ready, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_edge_gap))
    `ASSERT_NEXT(a_cfg_ratio, aclk, aresetn,
        cfg_we && (cfg_index == veas_pkg::REG_RATIO), ratio_reg == $past(cfg_wdata))
endmodule

@@ hw/rtl/veas_cordic.sv @@
// Pipelined CORDIC stage chain producing Q30 cosine and sine of one angle.
`timescale 1ns / 1ps
module veas_cordic #(
    parameter int ANGLE_BITS = veas_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = veas_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic signed [33:0]    cos_q30,
    output logic signed [33:0]    sin_q30
);
    localparam int STEPS = (CORDIC_STEPS > veas_pkg::TABLE_LEN) ?
        veas_pkg::TABLE_LEN : CORDIC_STEPS;

    logic signed [33:0] x_reg [STEPS+1];
    logic signed [33:0] y_reg [STEPS+1];
    logic signed [33:0] z_reg [STEPS+1];
    logic               neg_reg [STEPS+1];

    logic [31:0] a32;
    logic [31:0] a_rot;
    logic        quad_neg;

    always_comb begin
        a32 = {angle, {(32-ANGLE_BITS){1'b0}}};
        quad_neg = (a32[31:30] == 2'd1) || (a32[31:30] == 2'd2);
        a_rot = quad_neg ? (a32 + 32'h8000_0000) : a32;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= 34'(veas_pkg::CORDIC_GAIN_Q30);
            y_reg[0] <= '0;
            z_reg[0] <= {{2{a_rot[31]}}, a_rot};
            neg_reg[0] <= quad_neg;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][33]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - veas_pkg::atan_turn32(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + veas_pkg::atan_turn32(i);
                end
            end
        end
    end

    assign cos_q30 = neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
    assign sin_q30 = neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
endmodule

@@ hw/rtl/veas_select.sv @@
// Projection, distance compare and threshold decision pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module veas_select (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               v_in,
    input  logic signed [33:0] mc,
    input  logic signed [33:0] ms,
    input  logic signed [33:0] pc,
    input  logic signed [33:0] ps,
    input  logic signed [23:0] mx,
    input  logic signed [23:0] my,
    input  logic [13:0]        ml,
    input  logic signed [23:0] px,
    input  logic signed [23:0] py,
    input  logic [13:0]        pl,
    input  logic [15:0]        ratio_thr,
    input  logic [15:0]        abs_thr,
    output logic               v_out,
    output logic [1:0]         kind,
    output logic signed [23:0] ax,
    output logic signed [23:0] ay,
    output logic [23:0]        gap
);
    // Stage A: edge offset products.
    logic signed [48:0] oxp_reg, oyp_reg;
    logic signed [33:0] pc_a_reg, ps_a_reg;
    logic signed [23:0] mx_a_reg, my_a_reg, px_a_reg, py_a_reg;
    logic [13:0]        ml_a_reg, pl_a_reg;
    logic               v_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            oxp_reg <= 49'($signed({1'b0, ml})) * 49'(mc) + 49'sd1073741824;
            oyp_reg <= 49'($signed({1'b0, ml})) * 49'(ms) + 49'sd1073741824;
            pc_a_reg <= pc; ps_a_reg <= ps;
            mx_a_reg <= mx; my_a_reg <= my; px_a_reg <= px; py_a_reg <= py;
            ml_a_reg <= ml; pl_a_reg <= pl;
        end
    end

    // Stage B: edge positions.
    logic signed [25:0] fx_reg, fy_reg, rx_reg, ry_reg;
    logic signed [33:0] pc_b_reg, ps_b_reg;
    logic signed [23:0] px_b_reg, py_b_reg;
    logic [13:0]        ml_b_reg, pl_b_reg;
    logic signed [17:0] ox, oy;
    logic               v_b_reg;

    assign ox = 18'(oxp_reg >>> 31);
    assign oy = 18'(oyp_reg >>> 31);

    always_ff @(posedge aclk) begin
        if (en) begin
            fx_reg <= 26'(mx_a_reg) + 26'(ox);
            fy_reg <= 26'(my_a_reg) + 26'(oy);
            rx_reg <= 26'(mx_a_reg) - 26'(ox);
            ry_reg <= 26'(my_a_reg) - 26'(oy);
            pc_b_reg <= pc_a_reg; ps_b_reg <= ps_a_reg;
            px_b_reg <= px_a_reg; py_b_reg <= py_a_reg;
            ml_b_reg <= ml_a_reg; pl_b_reg <= pl_a_reg;
        end
    end

    // Stage C: projection products.
    logic signed [59:0] fxp_reg, fyp_reg, rxp_reg, ryp_reg, pxp_reg, pyp_reg;
    logic signed [25:0] fx_c_reg, fy_c_reg, rx_c_reg, ry_c_reg;
    logic [13:0]        pl_c_reg;
    logic [13:0]        lmax_c_reg;
    logic               v_c_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            fxp_reg <= 60'(fx_reg) * 60'(pc_b_reg);
            fyp_reg <= 60'(fy_reg) * 60'(ps_b_reg);
            rxp_reg <= 60'(rx_reg) * 60'(pc_b_reg);
            ryp_reg <= 60'(ry_reg) * 60'(ps_b_reg);
            pxp_reg <= 60'(px_b_reg) * 60'(pc_b_reg);
            pyp_reg <= 60'(py_b_reg) * 60'(ps_b_reg);
            fx_c_reg <= fx_reg; fy_c_reg <= fy_reg;
            rx_c_reg <= rx_reg; ry_c_reg <= ry_reg;
            pl_c_reg <= pl_b_reg;
            lmax_c_reg <= (ml_b_reg > pl_b_reg) ? ml_b_reg : pl_b_reg;
        end
    end

    // Stage D: axis positions.
    logic signed [61:0] mf_reg, mr_reg, pf_reg, pr_reg;
    logic signed [25:0] fx_d_reg, fy_d_reg, rx_d_reg, ry_d_reg;
    logic [13:0]        lmax_d_reg;
    logic signed [61:0] pcen;
    logic               v_d_reg;

    assign pcen = 62'(pxp_reg) + 62'(pyp_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            mf_reg <= 62'(fxp_reg) + 62'(fyp_reg);
            mr_reg <= 62'(rxp_reg) + 62'(ryp_reg);
            pf_reg <= pcen + $signed({19'd0, pl_c_reg, 29'd0});
            pr_reg <= pcen - $signed({19'd0, pl_c_reg, 29'd0});
            fx_d_reg <= fx_c_reg; fy_d_reg <= fy_c_reg;
            rx_d_reg <= rx_c_reg; ry_d_reg <= ry_c_reg;
            lmax_d_reg <= lmax_c_reg;
        end
    end

    // Stage E: distances and threshold product.
    logic [61:0]        d_reg [4];
    logic [45:0]        thr_reg;
    logic signed [25:0] fx_e_reg, fy_e_reg, rx_e_reg, ry_e_reg;
    logic               v_e_reg;
    logic [61:0]        d_next [4];
    logic [29:0]        thr_prod;
    logic [45:0]        thr_ratio;
    logic [45:0]        thr_abs;

    function automatic logic [61:0] absd(input logic signed [61:0] a,
                                         input logic signed [61:0] b);
        logic signed [62:0] t;
        t = 63'(a) - 63'(b);
        return t[62] ? 62'(-t) : 62'(t);
    endfunction

    always_comb begin
        d_next[0] = absd(mf_reg, pf_reg);
        d_next[1] = absd(mr_reg, pf_reg);
        d_next[2] = absd(mf_reg, pr_reg);
        d_next[3] = absd(mr_reg, pr_reg);
        thr_prod = 30'(ratio_thr) * 30'(lmax_d_reg);
        thr_ratio = {2'b0, thr_prod, 14'd0};
        thr_abs = {abs_thr, 30'd0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
            thr_reg <= (thr_ratio > thr_abs) ? thr_ratio : thr_abs;
            fx_e_reg <= fx_d_reg; fy_e_reg <= fy_d_reg;
            rx_e_reg <= rx_d_reg; ry_e_reg <= ry_d_reg;
        end
    end

    // Stage F: pairwise minimum.
    logic [61:0] m01_reg, m23_reg;
    logic        s01_reg, s23_reg;
    logic [45:0] thr_f_reg;
    logic signed [25:0] fx_f_reg, fy_f_reg, rx_f_reg, ry_f_reg;
    logic        v_f_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s01_reg <= d_reg[1] < d_reg[0];
            m01_reg <= (d_reg[1] < d_reg[0]) ? d_reg[1] : d_reg[0];
            s23_reg <= d_reg[3] < d_reg[2];
            m23_reg <= (d_reg[3] < d_reg[2]) ? d_reg[3] : d_reg[2];
            thr_f_reg <= thr_reg;
            fx_f_reg <= fx_e_reg; fy_f_reg <= fy_e_reg;
            rx_f_reg <= rx_e_reg; ry_f_reg <= ry_e_reg;
        end
    end

    // Stage G: final choice and result.
    logic [1:0]         kind_reg;
    logic signed [23:0] ax_reg, ay_reg;
    logic [23:0]        gap_reg;
    logic               v_g_reg;
    logic               pick_rear;
    logic               meas_rear;
    logic [61:0]        best;
    logic [62:0]        gap_r;
    logic signed [25:0] sx, sy;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607) return 24'sh7FFFFF;
        if (v < -26'sd8388608) return 24'sh800000;
        return 24'(v);
    endfunction

    always_comb begin
        pick_rear = m23_reg < m01_reg;
        best = pick_rear ? m23_reg : m01_reg;
        meas_rear = pick_rear ? s23_reg : s01_reg;
        gap_r = (63'(best) + 63'd536870912) >> 30;
        sx = meas_rear ? rx_f_reg : fx_f_reg;
        sy = meas_rear ? ry_f_reg : fy_f_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gap_reg <= (gap_r > 63'd16777215) ? 24'hFFFFFF : 24'(gap_r);
            if (best < 62'(thr_f_reg)) begin
                kind_reg <= pick_rear ? veas_pkg::KIND_REAR : veas_pkg::KIND_FRONT;
                ax_reg <= sat24(sx);
                ay_reg <= sat24(sy);
            end else begin
                kind_reg <= veas_pkg::KIND_WEAK;
                ax_reg <= '0;
                ay_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0; v_b_reg <= 1'b0; v_c_reg <= 1'b0; v_d_reg <= 1'b0;
            v_e_reg <= 1'b0; v_f_reg <= 1'b0; v_g_reg <= 1'b0;
        end else if (en) begin
            v_a_reg <= v_in; v_b_reg <= v_a_reg; v_c_reg <= v_b_reg;
            v_d_reg <= v_c_reg; v_e_reg <= v_d_reg; v_f_reg <= v_e_reg;
            v_g_reg <= v_f_reg;
        end
    end

    assign v_out = v_g_reg;
    assign kind = kind_reg;
    assign ax = ax_reg;
    assign ay = ay_reg;
    assign gap = gap_reg;

    `ASSERT_IMPL(a_weak_zero, aclk, aresetn,
        v_g_reg && (kind_reg == veas_pkg::KIND_WEAK), (ax_reg == '0) && (ay_reg == '0))
    `ASSERT_IMPL(a_kind_legal, aclk, aresetn, v_g_reg, kind_reg != 2'd3)
    `ASSERT_NEXT(a_hold, aclk, aresetn, !en, $stable(v_g_reg) && $stable(gap_reg))
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the vehicle edge alignment selector.
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic signed [23:0] mx, my;
        logic [15:0]        mh;
        logic [13:0]        ml;
        logic signed [23:0] px, py;
        logic [15:0]        ph;
        logic [13:0]        pl;
    } box_pair_t;

    typedef struct {
        logic [1:0]         kind;
        logic signed [23:0] ax, ay;
        logic [23:0]        gap;
    } alignment_t;

    class alignment_scoreboard;
        alignment_t pending[$];
        logic [15:0] ratio_q16;
        logic [15:0] abs_thr;
        int errors;

        function new();
            ratio_q16 = 16'd13107;
            abs_thr = 16'd256;
            errors = 0;
        endfunction

        function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        function void heading_sincos(logic [15:0] hd, output longint c, output longint s);
            longint x, y, z, dx, dy;
            logic [31:0] a;
            bit flip;
            a = {hd, 16'h0};
            flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
            if (flip) a = a + 32'h8000_0000;
            z = longint'($signed(a));
            x = longint'(veas_pkg::CORDIC_GAIN_Q30);
            y = 0;
            for (int i = 0; i < veas_pkg::CORDIC_STEPS_DEF; i++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(veas_pkg::atan_turn32(i));
                end else begin
                    x += dx; y -= dy; z += longint'(veas_pkg::atan_turn32(i));
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            c = x;
            s = y;
        endfunction

        function longint clamp24(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function void note_request(box_pair_t b);
            longint mc, ms, pc, ps, ox, oy, fx, fy, rx, ry, mf, mr, pcen, pf, pr;
            longint mlen, plen, d[4], best, thr_r, thr_a, thr, gp;
            int bi;
            alignment_t r;
            heading_sincos(b.mh, mc, ms);
            heading_sincos(b.ph, pc, ps);
            mlen = longint'(b.ml);
            plen = longint'(b.pl);
            ox = floor_shift(mlen * mc + (64'sd1 <<< 30), 31);
            oy = floor_shift(mlen * ms + (64'sd1 <<< 30), 31);
            fx = longint'(b.mx) + ox; fy = longint'(b.my) + oy;
            rx = longint'(b.mx) - ox; ry = longint'(b.my) - oy;
            mf = fx * pc + fy * ps;
            mr = rx * pc + ry * ps;
            pcen = longint'(b.px) * pc + longint'(b.py) * ps;
            pf = pcen + plen * (64'sd1 <<< 29);
            pr = pcen - plen * (64'sd1 <<< 29);
            d[0] = mf > pf ? mf - pf : pf - mf;
            d[1] = mr > pf ? mr - pf : pf - mr;
            d[2] = mf > pr ? mf - pr : pr - mf;
            d[3] = mr > pr ? mr - pr : pr - mr;
            best = d[0];
            bi = 0;
            for (int k = 1; k < 4; k++)
                if (d[k] < best) begin
                    best = d[k]; bi = k;
                end
            thr_r = (longint'(ratio_q16) * (mlen > plen ? mlen : plen)) <<< 14;
            thr_a = longint'(abs_thr) <<< 30;
            thr = thr_r > thr_a ? thr_r : thr_a;
            gp = (best + (64'sd1 <<< 29)) >>> 30;
            r.gap = gp > 64'sd16777215 ? 24'hFFFFFF : gp[23:0];
            if (best < thr) begin
                r.kind = bi < 2 ? veas_pkg::KIND_FRONT : veas_pkg::KIND_REAR;
                r.ax = 24'(clamp24((bi == 0 || bi == 2) ? fx : rx));
                r.ay = 24'(clamp24((bi == 0 || bi == 2) ? fy : ry));
            end else begin
                r.kind = veas_pkg::KIND_WEAK;
                r.ax = '0;
                r.ay = '0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(alignment_t a);
            alignment_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind=%0d", $time, a.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, e.kind, a.kind);
                errors++;
            end
            if (a.ax !== e.ax) begin
                $display("%0t: anchor_x expected %0d actual %0d", $time, e.ax, a.ax);
                errors++;
            end
            if (a.ay !== e.ay) begin
                $display("%0t: anchor_y expected %0d actual %0d", $time, e.ay, a.ay);
                errors++;
            end
            if (a.gap !== e.gap) begin
                $display("%0t: edge_gap expected %0d actual %0d", $time, e.gap, a.gap);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_we, cfg_index;
    logic [15:0] cfg_wdata;
    logic s_valid, s_ready, m_valid, m_ready;
    logic signed [23:0] s_meas_x, s_meas_y, s_pred_x, s_pred_y;
    logic [15:0] s_meas_heading, s_pred_heading;
    logic [13:0] s_meas_length, s_pred_length;
    logic [1:0] m_update_kind;
    logic signed [23:0] m_anchor_x, m_anchor_y;
    logic [23:0] m_edge_gap;

    alignment_scoreboard board;
    bit calm;

    vehicle_edge_alignment_select_top u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_update_kind, m_anchor_x, m_anchor_y, m_edge_gap});
    end

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 27);
    end

    task automatic send_pair(box_pair_t b);
        while (!calm && $urandom_range(0, 99) < 27) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_meas_x <= b.mx; s_meas_y <= b.my;
        s_meas_heading <= b.mh; s_meas_length <= b.ml;
        s_pred_x <= b.px; s_pred_y <= b.py;
        s_pred_heading <= b.ph; s_pred_length <= b.pl;
        do @(posedge aclk); while (!s_ready);
        board.note_request(b);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == veas_pkg::REG_RATIO) board.ratio_q16 = v;
        else board.abs_thr = v;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    function automatic box_pair_t random_pair(int mode);
        box_pair_t b;
        b.mx = $urandom; b.my = $urandom;
        b.mh = $urandom; b.ml = $urandom;
        b.px = $urandom; b.py = $urandom;
        b.ph = $urandom; b.pl = $urandom;
        if (mode != 0) begin
            // Nearby boxes with similar or reversed heading so that edge updates occur.
            b.ml = $urandom_range(0, 1600);
            b.pl = b.ml + $urandom_range(0, 200);
            b.mx = $urandom_range(0, 200000) - 100000;
            b.my = $urandom_range(0, 200000) - 100000;
            b.px = b.mx + $urandom_range(0, 800) - 400;
            b.py = b.my + $urandom_range(0, 800) - 400;
            b.ph = $urandom;
            b.mh = (mode == 2) ? b.ph + 16'h8000 + $urandom_range(0, 600) - 300
                               : b.ph + $urandom_range(0, 600) - 300;
        end
        return b;
    endfunction

    initial begin
        box_pair_t b;
        board = new();
        calm = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_index = veas_pkg::REG_RATIO; cfg_wdata = '0;
        s_valid = 1'b0;
        s_meas_x = '0; s_meas_y = '0; s_meas_heading = '0; s_meas_length = '0;
        s_pred_x = '0; s_pred_y = '0; s_pred_heading = '0; s_pred_length = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, identical boxes, reversed boxes, saturation.
        send_pair('{0, 0, 0, 0, 0, 0, 0, 0});
        send_pair('{24'sh7FFFFF, 24'sh7FFFFF, 0, 14'h3FFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 14'h3FFF});
        send_pair('{-24'sd8388608, -24'sd8388608, 16'h8000, 14'h3FFF,
                    -24'sd8388608, -24'sd8388608, 16'h8000, 14'h3FFF});
        send_pair('{24'sh7FFFFF, 0, 0, 14'h3FFF, -24'sd8388608, 0, 0, 0});
        send_pair('{1000, 500, 16'h4000, 1000, 1000, 500, 16'hC000, 1000});
        send_pair('{1000, 500, 16'h2000, 1000, 1010, 500, 16'h2000, 1100});
        send_pair('{0, 0, 16'hFFFF, 800, 100, -100, 16'h6000, 500});
        send_pair('{-5000, 7000, 16'hA000, 14'h3FFF, -4000, 7000, 16'h2000, 14'h3FFF});
        send_pair('{0, 0, 16'h4000, 1000, 0, 300, 16'h4000, 1000});
        send_pair('{24'sh7FFFF0, -24'sd8388600, 16'h1234, 14'h3FFF,
                    -24'sd8388608, 24'sh7FFFFF, 16'hFEDC, 0});
        drain();
        write_reg(veas_pkg::REG_RATIO, 16'h0000);
        write_reg(veas_pkg::REG_ABS, 16'h0000);
        send_pair('{0, 0, 0, 0, 0, 0, 0, 0});
        send_pair('{1000, 500, 16'h2000, 1000, 1000, 500, 16'h2000, 1000});
        drain();
        write_reg(veas_pkg::REG_RATIO, 16'hFFFF);
        write_reg(veas_pkg::REG_ABS, 16'hFFFF);
        send_pair('{1000, 500, 16'h2000, 1000, 9000, 500, 16'h2000, 1000});
        send_pair('{24'sh7FFFFF, 0, 0, 14'h3FFF, -24'sd8388608, 0, 0, 14'h3FFF});
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(veas_pkg::REG_RATIO, 16'd13107);
                    write_reg(veas_pkg::REG_ABS, 16'd256);
                end
                1: begin
                    write_reg(veas_pkg::REG_RATIO, $urandom);
                    write_reg(veas_pkg::REG_ABS, $urandom);
                end
                2: begin
                    write_reg(veas_pkg::REG_RATIO, 16'd0);
                    write_reg(veas_pkg::REG_ABS, 16'd64);
                end
                default: begin
                    write_reg(veas_pkg::REG_RATIO, 16'hFFFF);
                    write_reg(veas_pkg::REG_ABS, 16'd0);
                end
            endcase
            for (int n = 0; n < 260; n++) begin
                calm = (phase == 1) && (n >= 60) && (n < 140);
                b = random_pair($urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2));
                send_pair(b);
                if (phase == 2 && n == 100) begin
                    s_valid <= 1'b0;
                    while (board.pending.size() != 0) @(negedge aclk);
                end
            end
            calm = 1'b0;
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/veas_pkg.sv
hw/rtl/veas_cordic.sv
hw/rtl/veas_select.sv
hw/rtl/vehicle_edge_alignment_select_top.sv
dv/testbench.sv
